### hdl/sca_pkg.sv
// Shared types, codes and size-class helpers for the slab size-class allocator.
// Depends on nothing; sca_free_decode, the allocator and the bench import it.
package sca_pkg;

    localparam int NUM_CLASSES = 9;
    localparam int PAGE_BYTES  = 4096;
    localparam int SLOT_BITS   = 8;

    localparam logic [7:0] NO_SLOT    = 8'hFF;
    localparam logic [3:0] CLS_NONE   = 4'd9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic [3:0] CLS_1536 = 4'd7;
    localparam logic [3:0] CLS_2048 = 4'd8;

    // Result of decoding a free address inside a page
    typedef struct packed {
        logic       ok;
        logic [7:0] slot;
    } free_dec_t;

    // Smallest class that holds the size; CLS_NONE when too large
    function automatic logic [3:0] class_of_size(input logic [15:0] size);
        logic [3:0] c;
        c = CLS_NONE;
        priority if (size <= 16'd16)   c = 4'd0;
        else if (size <= 16'd32)        c = 4'd1;
        else if (size <= 16'd64)        c = 4'd2;
        else if (size <= 16'd128)       c = 4'd3;
        else if (size <= 16'd256)       c = 4'd4;
        else if (size <= 16'd512)       c = 4'd5;
        else if (size <= 16'd1024)      c = 4'd6;
        else if (size <= 16'd1536)      c = 4'd7;
        else if (size <= 16'd2048)      c = 4'd8;
        else                            c = CLS_NONE;
        return c;
    endfunction

    // Byte offset of a slot within the slot area: slot times class size
    function automatic logic [19:0] slot_offset(input logic [3:0] cls, input logic [7:0] slot);
        logic [19:0] s;
        logic [19:0] r;
        s = 20'(slot);
        unique case (cls)
            4'd0:     r = s << 4;
            4'd1:     r = s << 5;
            4'd2:     r = s << 6;
            4'd3:     r = s << 7;
            4'd4:     r = s << 8;
            4'd5:     r = s << 9;
            4'd6:     r = s << 10;
            CLS_1536: r = (s << 10) + (s << 9);
            CLS_2048: r = s << 11;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

### hdl/sca_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Depends on nothing.
module sca_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [D];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/sca_free_decode.sv
// Free-address check: header, slot boundary and slot count for one class.
// Depends on sca_pkg.
module sca_free_decode #(
    parameter int HEADER_BYTES = 48
) (
    input  logic [3:0]          cls,
    input  logic [11:0]         pg_off,
    input  logic [7:0]          slots,
    output sca_pkg::free_dec_t  dec
);
    import sca_pkg::*;

    localparam logic [11:0] HDR = 12'(HEADER_BYTES);

    logic [11:0] rel;
    logic [11:0] quot;
    logic        on_bound;

    assign rel = pg_off - HDR;

    // Split the offset into slot index and remainder
    always_comb begin
        unique case (cls)
            4'd0:     begin quot = rel >> 4;  on_bound = (rel[3:0] == '0);  end
            4'd1:     begin quot = rel >> 5;  on_bound = (rel[4:0] == '0);  end
            4'd2:     begin quot = rel >> 6;  on_bound = (rel[5:0] == '0);  end
            4'd3:     begin quot = rel >> 7;  on_bound = (rel[6:0] == '0);  end
            4'd4:     begin quot = rel >> 8;  on_bound = (rel[7:0] == '0);  end
            4'd5:     begin quot = rel >> 9;  on_bound = (rel[8:0] == '0);  end
            4'd6:     begin quot = rel >> 10; on_bound = (rel[9:0] == '0);  end
            CLS_1536: begin
                quot     = (rel >= 12'd3072) ? 12'd2 : ((rel >= 12'd1536) ? 12'd1 : 12'd0);
                on_bound = (rel == 12'd0) || (rel == 12'd1536) || (rel == 12'd3072);
            end
            CLS_2048: begin quot = rel >> 11; on_bound = (rel[10:0] == '0); end
            default:  begin quot = '0;        on_bound = 1'b0;              end
        endcase
    end

    assign dec.ok   = (pg_off >= HDR) && on_bound && (quot < 12'(slots));
    assign dec.slot = quot[7:0];
endmodule

### hdl/slab_size_class_allocator.sv
// Slab size-class allocator, one request at a time.
// Per request: a free reads the page record, checks the address, then checks and frees the slot;
// an allocate walks the class list, claims a fresh page when no page on it has a free slot
// (linking it after the list tail when the list holds a page, then threading its slots, one
// slot link per cycle), pops a slot and forms its address; oversized or exhausted ends early.
// A new request is taken only in idle; a held result word stretches the finish state.
// Reset: synchronous active-low aresetn empties all class lists and page count, zeroes pool_base.
module slab_size_class_allocator #(
    parameter int POOL_PAGES   = 16,
    parameter int HEADER_BYTES = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_tvalid,
    output logic        cfg_tready,
    input  logic [47:0] cfg_tdata,   // pool_base
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // request_size[15:0], address[63:16]
    input  logic        s_tuser,     // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // slot_address[47:0], size_class[51:48], zero pad
    output logic [1:0]  m_tuser      // status
);
    import sca_pkg::*;

    localparam int PW   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int PPW  = $clog2(POOL_PAGES + 1);
    localparam int SAW  = PW + SLOT_BITS;
    localparam logic [PPW-1:0] NO_PAGE = PPW'(POOL_PAGES);
    localparam int AREA = PAGE_BYTES - HEADER_BYTES;
    localparam logic [7:0] SLOTS [NUM_CLASSES] = '{
        8'(AREA / 16), 8'(AREA / 32), 8'(AREA / 64), 8'(AREA / 128), 8'(AREA / 256),
        8'(AREA / 512), 8'(AREA / 1024), 8'(AREA / 1536), 8'(AREA / 2048)};

    typedef struct packed {
        logic [3:0]     cls;
        logic [PPW-1:0] link;
        logic [7:0]     head;
        logic [7:0]     count;
    } page_rec_t;

    typedef struct packed {
        logic [7:0] link;
        logic       busy;
    } slot_rec_t;

    localparam logic [3:0] S_IDLE = 4'd0,  S_WALK_RD = 4'd1, S_WALK_CHK = 4'd2,
                           S_CLAIM = 4'd3, S_LINK_RD = 4'd4, S_LINK_WR = 4'd5,
                           S_THREAD = 4'd6, S_POP_RD = 4'd7, S_POP_WR = 4'd8,
                           S_ADDR1 = 4'd9, S_ADDR2 = 4'd10, S_F_RD = 4'd11,
                           S_F_CHK = 4'd12, S_F_SLOT = 4'd13, S_DONE = 4'd14;

    logic [3:0]     state_reg, state_next;
    logic [47:0]    base_reg;
    logic [PPW-1:0] taken_reg, taken_next;
    logic [PPW-1:0] head_reg [NUM_CLASSES];
    logic [PPW-1:0] tail_reg [NUM_CLASSES];
    logic           head_we, tail_we;
    logic [PPW-1:0] head_wval, tail_wval;
    logic [3:0]     cls_reg, cls_next;
    logic [PPW-1:0] cur_reg, cur_next;
    logic [PPW-1:0] prev_reg, prev_next;
    logic [PW-1:0]  page_reg, page_next;
    page_rec_t      rec_reg, rec_next;
    logic [7:0]     slot_reg, slot_next;
    logic [7:0]     thr_reg, thr_next;
    logic [47:0]    off_reg, off_next;
    logic [47:0]    part_reg, part_next;
    logic [19:0]    soff_reg, soff_next;
    logic [1:0]     rstat_reg, rstat_next;
    logic [47:0]    raddr_reg, raddr_next;
    logic [3:0]     rcls_reg, rcls_next;
    logic           mval_reg, mval_next;
    logic [55:0]    mdata_reg, mdata_next;
    logic [1:0]     muser_reg, muser_next;

    logic           pg_we;
    logic [PW-1:0]  pg_waddr, pg_raddr;
    page_rec_t      pg_wdata, pg_rdata;
    logic           sl_we;
    logic [SAW-1:0] sl_waddr, sl_raddr;
    slot_rec_t      sl_wdata, sl_rdata;

    logic [3:0]     in_cls;
    logic [7:0]     n_cur, n_rd;
    free_dec_t      dec;

    // Per-page records and per-slot links
    sca_ram #(.W($bits(page_rec_t)), .D(POOL_PAGES), .AW(PW)) u_page_ram (
        .aclk(aclk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(pg_raddr), .rdata(pg_rdata));

    sca_ram #(.W($bits(slot_rec_t)), .D(POOL_PAGES * 256), .AW(SAW)) u_slot_ram (
        .aclk(aclk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata));

    sca_free_decode #(.HEADER_BYTES(HEADER_BYTES)) u_dec (
        .cls(pg_rdata.cls), .pg_off(off_reg[11:0]), .slots(n_rd), .dec(dec));

    assign in_cls = class_of_size(s_tdata[15:0]);
    assign n_cur  = (cls_reg < 4'(NUM_CLASSES)) ? SLOTS[cls_reg] : 8'd0;
    assign n_rd   = (pg_rdata.cls < 4'(NUM_CLASSES)) ? SLOTS[pg_rdata.cls] : 8'd0;

    assign cfg_tready = 1'b1;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = mval_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser    = muser_reg;

    // Sequencer: walk, claim, thread, pop, and free
    always_comb begin
        state_next = state_reg;
        taken_next = taken_reg;
        cls_next   = cls_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        page_next  = page_reg;
        rec_next   = rec_reg;
        slot_next  = slot_reg;
        thr_next   = thr_reg;
        off_next   = off_reg;
        part_next  = part_reg;
        soff_next  = soff_reg;
        rstat_next = rstat_reg;
        raddr_next = raddr_reg;
        rcls_next  = rcls_reg;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        head_wval  = PPW'(page_reg);
        tail_wval  = PPW'(page_reg);
        pg_we      = 1'b0;
        pg_waddr   = page_reg;
        pg_wdata   = rec_reg;
        pg_raddr   = cur_reg[PW-1:0];
        sl_we      = 1'b0;
        sl_waddr   = {page_reg, thr_reg};
        sl_wdata   = '{link: NO_SLOT, busy: 1'b0};
        sl_raddr   = {page_reg, rec_reg.head};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    rstat_next = ST_OK;
                    raddr_next = '0;
                    rcls_next  = '0;
                    off_next   = s_tdata[63:16] - base_reg;
                    if (s_tuser) begin
                        state_next = S_F_RD;
                    end else if (in_cls == CLS_NONE) begin
                        rstat_next = ST_TOO_LARGE;
                        state_next = S_DONE;
                    end else begin
                        cls_next  = in_cls;
                        rcls_next = in_cls;
                        cur_next  = head_reg[in_cls];
                        state_next = (head_reg[in_cls] == NO_PAGE) ? S_CLAIM : S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                pg_raddr   = cur_reg[PW-1:0];
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (pg_rdata.count != 8'd0) begin
                    page_next  = cur_reg[PW-1:0];
                    rec_next   = pg_rdata;
                    state_next = S_POP_RD;
                end else if (pg_rdata.link == NO_PAGE) begin
                    state_next = S_CLAIM;
                end else begin
                    cur_next   = pg_rdata.link;
                    state_next = S_WALK_RD;
                end
            end
            S_CLAIM: begin
                if (taken_reg == NO_PAGE) begin
                    rstat_next = ST_EXHAUSTED;
                    state_next = S_DONE;
                end else begin
                    page_next  = taken_reg[PW-1:0];
                    taken_next = taken_reg + 1'b1;
                    rec_next   = '{cls: cls_reg, link: NO_PAGE, head: 8'd0, count: n_cur};
                    pg_we      = 1'b1;
                    pg_waddr   = taken_reg[PW-1:0];
                    pg_wdata   = '{cls: cls_reg, link: NO_PAGE, head: 8'd0, count: n_cur};
                    prev_next  = tail_reg[cls_reg];
                    tail_we    = 1'b1;
                    tail_wval  = taken_reg;
                    thr_next   = '0;
                    if (tail_reg[cls_reg] == NO_PAGE) begin
                        head_we    = 1'b1;
                        head_wval  = taken_reg;
                        state_next = S_THREAD;
                    end else begin
                        state_next = S_LINK_RD;
                    end
                end
            end
            S_LINK_RD: begin
                pg_raddr   = prev_reg[PW-1:0];
                state_next = S_LINK_WR;
            end
            S_LINK_WR: begin
                pg_we         = 1'b1;
                pg_waddr      = prev_reg[PW-1:0];
                pg_wdata      = pg_rdata;
                pg_wdata.link = PPW'(page_reg);
                state_next    = S_THREAD;
            end
            S_THREAD: begin
                sl_we    = 1'b1;
                sl_waddr = {page_reg, thr_reg};
                sl_wdata = '{link: ((thr_reg + 8'd1) < n_cur) ? thr_reg + 8'd1 : NO_SLOT,
                             busy: 1'b0};
                thr_next = thr_reg + 8'd1;
                if ((thr_reg + 8'd1) >= n_cur) begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD: begin
                sl_raddr   = {page_reg, rec_reg.head};
                state_next = S_POP_WR;
            end
            S_POP_WR: begin
                pg_we          = 1'b1;
                pg_wdata       = rec_reg;
                pg_wdata.head  = sl_rdata.link;
                pg_wdata.count = rec_reg.count - 8'd1;
                sl_we          = 1'b1;
                sl_waddr       = {page_reg, rec_reg.head};
                sl_wdata       = '{link: sl_rdata.link, busy: 1'b1};
                slot_next      = rec_reg.head;
                state_next     = S_ADDR1;
            end
            S_ADDR1: begin
                part_next  = base_reg + (48'(page_reg) << 12);
                soff_next  = 20'(HEADER_BYTES) + slot_offset(cls_reg, slot_reg);
                state_next = S_ADDR2;
            end
            S_ADDR2: begin
                raddr_next = part_reg + 48'(soff_reg);
                state_next = S_DONE;
            end
            S_F_RD: begin
                pg_raddr = off_reg[PW+11:12];
                if (off_reg[47:12] >= 36'(taken_reg)) begin
                    rstat_next = ST_BAD_FREE;
                    state_next = S_DONE;
                end else begin
                    page_next  = off_reg[PW+11:12];
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK: begin
                sl_raddr = {page_reg, dec.slot};
                if (!dec.ok) begin
                    rstat_next = ST_BAD_FREE;
                    state_next = S_DONE;
                end else begin
                    rec_next   = pg_rdata;
                    slot_next  = dec.slot;
                    state_next = S_F_SLOT;
                end
            end
            S_F_SLOT: begin
                rcls_next = rec_reg.cls;
                if (!sl_rdata.busy) begin
                    rstat_next = ST_BAD_FREE;
                end else begin
                    sl_we          = 1'b1;
                    sl_waddr       = {page_reg, slot_reg};
                    sl_wdata       = '{link: (rec_reg.count != 8'd0) ? rec_reg.head : NO_SLOT,
                                       busy: 1'b0};
                    pg_we          = 1'b1;
                    pg_wdata       = rec_reg;
                    pg_wdata.head  = slot_reg;
                    pg_wdata.count = rec_reg.count + 8'd1;
                    rstat_next     = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mval_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register: load a finished word, drop it once taken
    always_comb begin
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        if (m_tready) begin
            mval_next = 1'b0;
        end
        if (state_reg == S_DONE && (!mval_reg || m_tready)) begin
            mval_next  = 1'b1;
            mdata_next = {4'd0, rcls_reg, raddr_reg};
            muser_next = rstat_reg;
        end
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            taken_reg <= '0;
            mval_reg  <= 1'b0;
            base_reg  <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= NO_PAGE;
                tail_reg[i] <= NO_PAGE;
            end
        end else begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            mval_reg  <= mval_next;
            if (cfg_tvalid) begin
                base_reg <= cfg_tdata;
            end
            if (head_we) begin
                head_reg[cls_reg] <= head_wval;
            end
            if (tail_we) begin
                tail_reg[cls_reg] <= tail_wval;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cls_reg   <= cls_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        page_reg  <= page_next;
        rec_reg   <= rec_next;
        slot_reg  <= slot_next;
        thr_reg   <= thr_next;
        off_reg   <= off_next;
        part_reg  <= part_next;
        soff_reg  <= soff_next;
        rstat_reg <= rstat_next;
        raddr_reg <= raddr_next;
        rcls_reg  <= rcls_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end
endmodule

### sim/slab_size_class_allocator_test.sv
// Self-checking bench for slab_size_class_allocator: queue-fed stream driver,
// a result monitor checked against an in-bench allocator predictor.
// Depends on sca_pkg and the slab_size_class_allocator RTL only.
module slab_size_class_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sca_pkg::*;

    localparam int PAGES = 16;
    localparam int HDR = 48;
    localparam int NO_PG = PAGES;
    localparam logic [3:0] PG_FREE = 4'd15;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;
    localparam logic [47:0] AMASK = 48'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 346;
    localparam int CLASS_BYTES [NUM_CLASSES] = '{16, 32, 64, 128, 256, 512, 1024, 1536, 2048};

    typedef struct {
        logic        act;
        logic [15:0] sz;
        logic [47:0] ad;
    } req_t;

    typedef struct {
        logic [1:0]  st;
        logic [47:0] ad;
        logic [3:0]  cls;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_tvalid = 1'b0;
    logic        cfg_tready;
    logic [47:0] cfg_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // request_size[15:0], address[63:16]
    logic        s_tuser = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // slot_address[47:0], size_class[51:48], zero pad
    logic [1:0]  m_tuser;        // status

    slab_size_class_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Allocator shadow state
    logic [47:0] base_addr = '0;
    logic [3:0]  pg_cls [PAGES];
    int          pg_taken;
    int          cls_head [NUM_CLASSES];
    int          cls_tail [NUM_CLASSES];
    int          pg_next [PAGES];
    logic [7:0]  pg_head [PAGES];
    int          pg_avail [PAGES];
    logic [7:0]  slot_next [PAGES*256];
    logic        slot_used [PAGES*256];

    req_t        req_q [$];
    grant_t      grant_q [$];
    logic [47:0] live_q [$];   // offsets from pool base of allocated slots
    logic [47:0] freed_q [$];

    bit calm = 0;
    bit failed = 0;
    int n_grants = 0;

    // Predict one request, update the shadow state and queue the word
    task automatic issue(input logic act, input logic [15:0] sz, input logic [47:0] ad,
                         output logic [47:0] got);
        grant_t g;
        int c, pg, steps, nslots, i, idx;
        logic [7:0] sl;
        logic [47:0] off, pg_off, rel;
        g.st = ST_OK; g.ad = '0; g.cls = '0;
        if (act == ACT_ALLOC) begin
            c = NUM_CLASSES;
            for (i = NUM_CLASSES - 1; i >= 0; i--)
                if (sz <= CLASS_BYTES[i]) c = i;
            if (c == NUM_CLASSES) begin
                g.st = ST_TOO_LARGE;
            end else begin
                g.cls = 4'(c);
                pg = cls_head[c];
                steps = 0;
                while (pg < PAGES && steps < PAGES && pg_avail[pg] == 0) begin
                    pg = pg_next[pg];
                    steps++;
                end
                if (pg >= PAGES || pg_avail[pg] == 0) begin
                    if (pg_taken >= PAGES) begin
                        g.st = ST_EXHAUSTED;
                        pg = -1;
                    end else begin
                        // Claim and thread a fresh page
                        pg = pg_taken++;
                        nslots = (4096 - HDR) / CLASS_BYTES[c];
                        for (i = 0; i < nslots; i++) begin
                            slot_next[pg*256+i] = (i + 1 < nslots) ? 8'(i + 1) : NO_SLOT;
                            slot_used[pg*256+i] = 1'b0;
                        end
                        pg_cls[pg] = 4'(c); pg_head[pg] = '0; pg_avail[pg] = nslots;
                        pg_next[pg] = NO_PG;
                        if (cls_tail[c] < PAGES) pg_next[cls_tail[c]] = pg;
                        else cls_head[c] = pg;
                        cls_tail[c] = pg;
                    end
                end
                if (pg >= 0) begin
                    // Pop the page's free list head
                    sl = pg_head[pg];
                    pg_head[pg] = slot_next[pg*256+sl];
                    pg_avail[pg]--;
                    slot_used[pg*256+sl] = 1'b1;
                    off = 48'(pg*4096 + HDR + int'(sl) * CLASS_BYTES[c]);
                    g.ad = (base_addr + off) & AMASK;
                    live_q.push_back(off);
                end
            end
        end else begin
            g.st = ST_BAD_FREE;
            off = (ad - base_addr) & AMASK;
            pg_off = off & 48'hFFF;
            if ((off >> 12) < pg_taken && (off >> 12) < PAGES) begin
                pg = int'(off >> 12);
                c = int'(pg_cls[pg]);
                if (c < NUM_CLASSES && pg_off >= HDR) begin
                    rel = pg_off - HDR;
                    if (rel % CLASS_BYTES[c] == 0
                        && rel / CLASS_BYTES[c] < (4096 - HDR) / CLASS_BYTES[c]) begin
                        sl = 8'(rel / CLASS_BYTES[c]);
                        g.cls = 4'(c);
                        if (slot_used[pg*256+sl]) begin
                            // Push the slot back onto the page's free list
                            slot_next[pg*256+sl] = (pg_avail[pg] > 0) ? pg_head[pg] : NO_SLOT;
                            pg_head[pg] = sl;
                            pg_avail[pg]++;
                            slot_used[pg*256+sl] = 1'b0;
                            g.st = ST_OK;
                            idx = -1;
                            foreach (live_q[k]) if (live_q[k] == off) idx = k;
                            if (idx >= 0) live_q.delete(idx);
                            freed_q.push_back(off);
                            if (freed_q.size() > 32) void'(freed_q.pop_front());
                        end
                    end
                end
            end
        end
        got = g.ad;
        req_q.push_back('{act, sz, ad});
        grant_q.push_back(g);
    endtask

    // Random request: mostly well-formed allocate/free traffic, some junk
    task automatic random_req();
        int r, k;
        logic [47:0] got, ad;
        r = $urandom_range(0, 99);
        ad = 48'({$urandom, $urandom});
        if (r < 45) begin
            k = $urandom_range(0, NUM_CLASSES - 1);
            issue(ACT_ALLOC, 16'($urandom_range(k ? CLASS_BYTES[k-1] + 1 : 0, CLASS_BYTES[k])),
                  ad, got);
        end else if (r < 50) begin
            issue(ACT_ALLOC, 16'($urandom_range(2049, 65535)), ad, got);
        end else if (r < 82 && live_q.size() > 0) begin
            k = $urandom_range(0, live_q.size() - 1);
            issue(ACT_FREE, 16'($urandom), (base_addr + live_q[k]) & AMASK, got);
        end else if (r < 87 && freed_q.size() > 0) begin
            k = $urandom_range(0, freed_q.size() - 1);
            issue(ACT_FREE, 16'($urandom), (base_addr + freed_q[k]) & AMASK, got);
        end else if (r < 95) begin
            ad = base_addr + 48'($urandom_range(0, PAGES*4096 - 1));
            issue(ACT_FREE, 16'($urandom), ad & AMASK, got);
        end else begin
            issue(ACT_FREE, 16'($urandom), ad, got);
        end
    endtask

    // Write pool_base once everything in flight has drained
    task automatic set_base(input logic [47:0] b);
        wait (req_q.size() == 0 && grant_q.size() == 0);
        repeat (400) @(posedge aclk);
        @(negedge aclk);
        cfg_tvalid <= 1'b1;
        cfg_tdata <= b;
        do @(posedge aclk); while (!cfg_tready);
        @(negedge aclk);
        cfg_tvalid <= 1'b0;
        base_addr = b;
    endtask

    // Input driver: present the next word after each acceptance
    bit s_acc = 0;
    int s_gap = 0;
    always @(posedge aclk) s_acc <= s_tvalid && s_tready;

    always @(negedge aclk) begin
        req_t it;
        if (aresetn && (!s_tvalid || s_acc)) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                it = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {it.ad, it.sz};
                s_tuser <= it.act;
                if (!calm && $urandom_range(0, 19) == 0) s_gap <= $urandom_range(1, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stall bursts plus one long hold-off
    int m_gap = 0;
    int m_hold = 0;
    bit pressed = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_hold > 0) begin
            m_hold <= m_hold - 1;
            m_tready <= 1'b0;
        end else if (!pressed && n_grants >= 300) begin
            pressed <= 1'b1;
            m_hold <= 600;
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 19) == 0) m_gap <= $urandom_range(1, 12);
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin
        grant_t g;
        if (m_tvalid && m_tready) begin
            n_grants <= n_grants + 1;
            if (grant_q.size() == 0) begin
                failed = 1;
                $display("%0t: unexpected result st=%0d addr=%h cls=%0d",
                         $time, m_tuser, m_tdata[47:0], m_tdata[51:48]);
            end else begin
                g = grant_q.pop_front();
                if (m_tuser !== g.st) begin
                    failed = 1;
                    $display("%0t: status expected %0d actual %0d", $time, g.st, m_tuser);
                end
                if (m_tdata[47:0] !== g.ad) begin
                    failed = 1;
                    $display("%0t: slot_address expected %h actual %h",
                             $time, g.ad, m_tdata[47:0]);
                end
                if (m_tdata[51:48] !== g.cls) begin
                    failed = 1;
                    $display("%0t: size_class expected %0d actual %0d",
                             $time, g.cls, m_tdata[51:48]);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_tvalid && cfg_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [47:0] a, big;
        pg_taken = 0;
        for (int i = 0; i < PAGES; i++) begin
            pg_cls[i] = PG_FREE; pg_next[i] = NO_PG; pg_head[i] = '0; pg_avail[i] = 0;
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cls_head[i] = NO_PG; cls_tail[i] = NO_PG;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: base near the top so pages wrap past zero
        set_base(48'hFFFF_FFFF_F000);
        issue(ACT_ALLOC, 16'd0, AMASK, a);
        issue(ACT_ALLOC, 16'd16, '0, a);
        issue(ACT_ALLOC, 16'd17, '0, a);
        issue(ACT_FREE, '0, a, a);                       // valid free
        issue(ACT_FREE, '0, (base_addr + 48'h1000 + HDR) & AMASK, a); // double free
        issue(ACT_ALLOC, 16'd2048, '0, big);
        issue(ACT_FREE, 16'hFFFF, (big + 48'd2048) & AMASK, a);  // slot past count
        issue(ACT_ALLOC, 16'd2049, '0, a);
        issue(ACT_ALLOC, 16'hFFFF, '0, a);
        issue(ACT_ALLOC, 16'd1536, '0, a);
        issue(ACT_ALLOC, 16'd1025, '0, a);
        issue(ACT_ALLOC, 16'd1024, '0, a);
        issue(ACT_ALLOC, 16'd512, '0, a);
        issue(ACT_ALLOC, 16'd256, '0, a);
        issue(ACT_ALLOC, 16'd128, '0, a);
        issue(ACT_ALLOC, 16'd64, '0, a);
        issue(ACT_FREE, '0, base_addr, a);                         // inside header
        issue(ACT_FREE, '0, (base_addr + HDR + 1) & AMASK, a);     // off boundary
        issue(ACT_FREE, '0, (base_addr + 15 * 4096 + HDR) & AMASK, a); // unclaimed page
        issue(ACT_FREE, '0, (base_addr - 16) & AMASK, a);          // below base
        issue(ACT_FREE, '0, big, a);
        issue(ACT_FREE, '0, big, a);

        // Random phases over several pool bases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_base('0);
                1: set_base(48'({$urandom, $urandom}));
                2: set_base(AMASK);
                3: set_base(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000);
                default: begin
                    set_base(48'({$urandom, $urandom}));
                    calm = 1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) random_req();
        end

        wait (req_q.size() == 0 && grant_q.size() == 0);
        repeat (400) @(posedge aclk);
        if (!failed && grant_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
